### rtl/mi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_pkg
// shared widths, payload types and arithmetic helpers of the moment invariants
// ----------------------------------------------------------------------------
package mi_pkg;

	localparam int MOMENT_WIDTH = 32;
	localparam int PRE_SHIFT    = 8;
	localparam int VAL_W        = 64;
	localparam int HALF_W       = VAL_W / 2;

	typedef logic [MOMENT_WIDTH-1:0] mom_t;
	typedef logic [VAL_W-1:0]        val_t;
	typedef logic [HALF_W-1:0]       half_t;

	typedef struct packed {
		mom_t m11;
		mom_t m12;
		mom_t m21;
		mom_t m02;
		mom_t m20;
		mom_t m03;
		mom_t m30;
	} mi_moms_t;

	typedef struct packed {
		val_t one;
		val_t d2;
		val_t p;
		val_t q;
		val_t a;
		val_t b;
		val_t m11;
	} mi_lin_t;

	typedef struct packed {
		logic ld_pp;
		logic ld_sum;
	} mi_mul_ctl_t;

	function automatic val_t prep(input mom_t m);
		val_t r;
		r = VAL_W'(m >> PRE_SHIFT);
		return r;
	endfunction

	function automatic val_t times3(input val_t x);
		val_t r;
		r = (x << 1) + x;
		return r;
	endfunction

	function automatic val_t mul_full(input half_t x, input half_t y);
		val_t r;
		r = x * y;
		return r;
	endfunction

	function automatic half_t mul_low(input half_t x, input half_t y);
		half_t r;
		r = x * y;
		return r;
	endfunction

endpackage

### rtl/mi_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_in_if
// input channel: one word of seven raw moments
// ----------------------------------------------------------------------------
interface mi_in_if import mi_pkg::*; ;
	logic valid;
	logic ready;
	mom_t mom_11;
	mom_t mom_12;
	mom_t mom_21;
	mom_t mom_02;
	mom_t mom_20;
	mom_t mom_03;
	mom_t mom_30;

	modport source (
		output valid, mom_11, mom_12, mom_21, mom_02, mom_20, mom_03, mom_30,
		input  ready
	);
	modport sink (
		input  valid, mom_11, mom_12, mom_21, mom_02, mom_20, mom_03, mom_30,
		output ready
	);
endinterface

### rtl/mi_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_out_if
// output channel: one word of six invariants
// ----------------------------------------------------------------------------
interface mi_out_if import mi_pkg::*; ;
	logic valid;
	logic ready;
	val_t inv_one;
	val_t inv_two;
	val_t inv_three;
	val_t inv_four;
	val_t inv_five;
	val_t inv_six;

	modport source (
		output valid, inv_one, inv_two, inv_three, inv_four, inv_five, inv_six,
		input  ready
	);
	modport sink (
		input  valid, inv_one, inv_two, inv_three, inv_four, inv_five, inv_six,
		output ready
	);
endinterface

### rtl/moment_invariants_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moment_invariants_core
// throughput: one word per cycle unless the output stalls; two cascaded
// 64-bit multiplies, each in two stages, set the depth
// reset clears the stage valid bits only, payload registers are not reset
// ----------------------------------------------------------------------------
module moment_invariants_core import mi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	mi_in_if.sink    in_ch,
	mi_out_if.source out_ch
);

	localparam int NSTG = 7;

	logic [NSTG:1]   vld;
	logic [NSTG+1:1] rdy;
	logic [NSTG:0]   vin;

	mi_moms_t    moms;
	mi_lin_t     lin_s1;
	mi_mul_ctl_t ctl_l1, ctl_l2;

	val_t one_s2, one_s3, d2_s2, d2_s3, m11_s2, m11_s3;
	val_t aa_s3, bb_s3, dd_s3, mm_s3, pp_s3, qq_s3, pa_s3, qb_s3, ab_s3;
	val_t inv1_s4, inv2_s4, inv3_s4, inv4_s4;
	val_t u_s4, v_s4, w_s4, pa_s4, qb_s4, d2_s4, m4_s4, ab_s4;
	val_t inv1_s5, inv2_s5, inv3_s5, inv4_s5;
	val_t inv1_s6, inv2_s6, inv3_s6, inv4_s6;
	val_t x_s6, y_s6, z_s6, t_s6;
	val_t inv1_s7, inv2_s7, inv3_s7, inv4_s7, inv5_s7, inv6_s7;

	// stage control: a stage loads when empty or when the next one moves
	always_comb begin
		rdy[NSTG+1] = out_ch.ready;
		for (int k = NSTG; k >= 1; k--) begin
			rdy[k] = !vld[k] || rdy[k+1];
		end
		vin = {vld, in_ch.valid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (rdy[k]) begin
					vld[k] <= vin[k-1];
				end
			end
		end
	end

	assign in_ch.ready = rdy[1];

	assign moms = '{m11: in_ch.mom_11, m12: in_ch.mom_12, m21: in_ch.mom_21,
		m02: in_ch.mom_02, m20: in_ch.mom_20, m03: in_ch.mom_03, m30: in_ch.mom_30};

	mi_front u_front (
		.clk    (clk),
		.en     (rdy[1]),
		.moms   (moms),
		.lin_s1 (lin_s1)
	);

	// first product level, stages 2 and 3
	assign ctl_l1 = '{ld_pp: rdy[2], ld_sum: rdy[3]};

	mi_mul u_aa (.clk(clk), .ctl(ctl_l1), .x(lin_s1.a),   .y(lin_s1.a),   .prod_s2(aa_s3));
	mi_mul u_bb (.clk(clk), .ctl(ctl_l1), .x(lin_s1.b),   .y(lin_s1.b),   .prod_s2(bb_s3));
	mi_mul u_dd (.clk(clk), .ctl(ctl_l1), .x(lin_s1.d2),  .y(lin_s1.d2),  .prod_s2(dd_s3));
	mi_mul u_mm (.clk(clk), .ctl(ctl_l1), .x(lin_s1.m11), .y(lin_s1.m11), .prod_s2(mm_s3));
	mi_mul u_pp (.clk(clk), .ctl(ctl_l1), .x(lin_s1.p),   .y(lin_s1.p),   .prod_s2(pp_s3));
	mi_mul u_qq (.clk(clk), .ctl(ctl_l1), .x(lin_s1.q),   .y(lin_s1.q),   .prod_s2(qq_s3));
	mi_mul u_pa (.clk(clk), .ctl(ctl_l1), .x(lin_s1.p),   .y(lin_s1.a),   .prod_s2(pa_s3));
	mi_mul u_qb (.clk(clk), .ctl(ctl_l1), .x(lin_s1.q),   .y(lin_s1.b),   .prod_s2(qb_s3));
	mi_mul u_ab (.clk(clk), .ctl(ctl_l1), .x(lin_s1.a),   .y(lin_s1.b),   .prod_s2(ab_s3));

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			one_s2 <= lin_s1.one;
			d2_s2  <= lin_s1.d2;
			m11_s2 <= lin_s1.m11;
		end
		if (rdy[3]) begin
			one_s3 <= one_s2;
			d2_s3  <= d2_s2;
			m11_s3 <= m11_s2;
		end
	end

	// sums of the first products
	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			inv1_s4 <= one_s3;
			inv2_s4 <= dd_s3 + (mm_s3 << 2);
			inv3_s4 <= pp_s3 + qq_s3;
			inv4_s4 <= aa_s3 + bb_s3;
			u_s4    <= aa_s3 - times3(bb_s3);
			v_s4    <= times3(aa_s3) - bb_s3;
			w_s4    <= aa_s3 - bb_s3;
			pa_s4   <= pa_s3;
			qb_s4   <= qb_s3;
			d2_s4   <= d2_s3;
			m4_s4   <= m11_s3 << 2;
			ab_s4   <= ab_s3;
		end
	end

	// second product level, stages 5 and 6
	assign ctl_l2 = '{ld_pp: rdy[5], ld_sum: rdy[6]};

	mi_mul u_x (.clk(clk), .ctl(ctl_l2), .x(pa_s4), .y(u_s4),  .prod_s2(x_s6));
	mi_mul u_y (.clk(clk), .ctl(ctl_l2), .x(qb_s4), .y(v_s4),  .prod_s2(y_s6));
	mi_mul u_z (.clk(clk), .ctl(ctl_l2), .x(d2_s4), .y(w_s4),  .prod_s2(z_s6));
	mi_mul u_t (.clk(clk), .ctl(ctl_l2), .x(m4_s4), .y(ab_s4), .prod_s2(t_s6));

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			inv1_s5 <= inv1_s4;
			inv2_s5 <= inv2_s4;
			inv3_s5 <= inv3_s4;
			inv4_s5 <= inv4_s4;
		end
		if (rdy[6]) begin
			inv1_s6 <= inv1_s5;
			inv2_s6 <= inv2_s5;
			inv3_s6 <= inv3_s5;
			inv4_s6 <= inv4_s5;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			inv1_s7 <= inv1_s6;
			inv2_s7 <= inv2_s6;
			inv3_s7 <= inv3_s6;
			inv4_s7 <= inv4_s6;
			inv5_s7 <= x_s6 + y_s6;
			inv6_s7 <= z_s6 + t_s6;
		end
	end

	assign out_ch.valid     = vld[NSTG];
	assign out_ch.inv_one   = inv1_s7;
	assign out_ch.inv_two   = inv2_s7;
	assign out_ch.inv_three = inv3_s7;
	assign out_ch.inv_four  = inv4_s7;
	assign out_ch.inv_five  = inv5_s7;
	assign out_ch.inv_six   = inv6_s7;

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld[1] |-> in_ch.ready)
		else $error("input not ready with stage 1 empty");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld[6] && !rdy[7] |=> vld[6] && $stable(x_s6) && $stable(t_s6))
		else $error("stage 6 word changed while stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && !vld[6] |=> !out_ch.valid)
		else $error("result word repeated after drain");
`endif

endmodule

### rtl/mi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_front
// first stage: moment pre-shift and the linear terms, registered
// ----------------------------------------------------------------------------
module mi_front import mi_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  mi_moms_t moms,
	output mi_lin_t  lin_s1
);

	val_t m11, m12, m21, m02, m20, m03, m30;

	always_comb begin
		m11 = prep(moms.m11);
		m12 = prep(moms.m12);
		m21 = prep(moms.m21);
		m02 = prep(moms.m02);
		m20 = prep(moms.m20);
		m03 = prep(moms.m03);
		m30 = prep(moms.m30);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lin_s1.one <= m20 + m02;
			lin_s1.d2  <= m20 - m02;
			lin_s1.p   <= m30 - times3(m12);
			lin_s1.q   <= times3(m21) - m03;
			lin_s1.a   <= m30 + m12;
			lin_s1.b   <= m21 + m03;
			lin_s1.m11 <= m11;
		end
	end

endmodule

### rtl/mi_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi_mul
// two-stage 64x64 multiplier keeping the low 64 bits of the product
// ----------------------------------------------------------------------------
module mi_mul import mi_pkg::*; (
	input  logic        clk,
	input  mi_mul_ctl_t ctl,
	input  val_t        x,
	input  val_t        y,
	output val_t        prod_s2
);

	val_t  ll_s1;
	half_t lh_s1;
	half_t hl_s1;

	// partial products, cross terms only need their low half
	always_ff @(posedge clk) begin
		if (ctl.ld_pp) begin
			ll_s1 <= mul_full(x[HALF_W-1:0], y[HALF_W-1:0]);
			lh_s1 <= mul_low(x[HALF_W-1:0], y[VAL_W-1:HALF_W]);
			hl_s1 <= mul_low(x[VAL_W-1:HALF_W], y[HALF_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_sum) begin
			prod_s2 <= ll_s1 + {lh_s1 + hl_s1, {HALF_W{1'b0}}};
		end
	end

endmodule
